>>> design/intel_hex_record_parser_assert.svh
// Assertion macros used by the parser's back end RTL file.
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define IHEX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ihex assertion failed");
// Check a property on every clock edge, reset included.
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ihex assertion failed");
`else
`define IHEX_ASSERT(lbl, clk, rst_n, prop)
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/ihex_pkg.sv
// Shared types, codes and character decode for the Intel HEX record parser.
package ihex_pkg;

    // character classes carried from front to back
    localparam logic [1:0] CLS_HEX   = 2'd0;
    localparam logic [1:0] CLS_COLON = 2'd1;
    localparam logic [1:0] CLS_LF    = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_DIGIT = 3'd0;
    localparam logic [2:0] ERR_COLON = 3'd1;
    localparam logic [2:0] ERR_COUNT = 3'd2;
    localparam logic [2:0] ERR_TYPE  = 3'd3;
    localparam logic [2:0] ERR_CSUM  = 3'd4;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_SEG  = 8'h02;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int ADDR_W     = 21;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] cls;
        logic [3:0] nib;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] block_size;
        logic [2:0]        error_code;
    } t_res;

    // Classify one character and give its nibble value when it is a hex digit.
    function automatic t_tok classify(input logic [7:0] c);
        t_tok t;
        t.cls = CLS_OTHER;
        t.nib = 4'd0;
        if (c > 8'h2F && c < 8'h3A) begin
            t.cls = CLS_HEX;
            t.nib = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            t.cls = CLS_HEX;
            t.nib = 4'(c[3:0] + 4'd9);
        end else if (c == CH_COLON) begin
            t.cls = CLS_COLON;
        end else if (c == CH_LF) begin
            t.cls = CLS_LF;
        end
        return t;
    endfunction

endpackage

>>> design/ihex_front.sv
// Front end: take characters, classify them and push tokens to the queue.
module ihex_front
    import ihex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  t_fifo_stat i_fstat,
    output logic       o_push,
    output t_tok       o_tok
);

    logic r_tok_vld;
    t_tok r_tok;
    logic w_take;

    assign o_stall = r_tok_vld && i_fstat.full;
    assign w_take  = i_valid && !o_stall;
    assign o_push  = r_tok_vld && !i_fstat.full;
    assign o_tok   = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else if (w_take) begin
            r_tok_vld <= 1'b1;
        end else if (o_push) begin
            r_tok_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tok <= classify(i_ch);
        end
    end

endmodule

>>> design/ihex_fifo.sv
// Short token queue between front and back.
module ihex_fifo
    import ihex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_tok       i_tok,
    input  logic       i_pop,
    output t_tok       o_tok,
    output t_fifo_stat o_fstat
);

    t_tok               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    assign o_fstat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_fstat.empty = (r_count == '0);
    assign o_tok         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= FIFO_AW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= FIFO_AW'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= FIFO_CW'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= FIFO_CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

>>> design/ihex_back.sv
// Back end: record state machine, block tracking and result register.
module ihex_back
    import ihex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tok       i_tok,
    input  t_fifo_stat i_fstat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output t_res       o_res
);

`include "intel_hex_record_parser_assert.svh"

    localparam logic [2:0] PH_COLON   = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_ADDR_HI = 3'd2;
    localparam logic [2:0] PH_ADDR_LO = 3'd3;
    localparam logic [2:0] PH_TYPE    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CHECK   = 3'd6;
    localparam logic [2:0] PH_TAIL    = 3'd7;

    logic [2:0]        r_phase,     n_phase;
    logic              r_nib_pend,  n_nib_pend;
    logic [3:0]        r_hi_nib,    n_hi_nib;
    logic [7:0]        r_count,     n_count;
    logic [7:0]        r_left,      n_left;
    logic [7:0]        r_addr_hi,   n_addr_hi;
    logic [7:0]        r_type,      n_type;
    logic [7:0]        r_sum,       n_sum;
    logic [15:0]       r_seg,       n_seg;
    logic [ADDR_W-1:0] r_base,      n_base;
    logic [ADDR_W-1:0] r_byte_addr, n_byte_addr;
    logic              r_blk_open,  n_blk_open;
    logic [ADDR_W-1:0] r_blk_start, n_blk_start;
    logic [ADDR_W-1:0] r_blk_bytes, n_blk_bytes;
    logic [ADDR_W-1:0] r_blk_end,   n_blk_end;
    logic              r_halted,    n_halted;
    logic              r_out_vld;
    t_res              r_out;

    logic [7:0]        w_byte;
    logic [7:0]        w_sum;
    logic [ADDR_W-1:0] w_base;
    logic              w_load;
    t_res              w_res;

    assign o_pop   = !i_fstat.empty && (!r_out_vld || !i_stall);
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    assign w_byte = {r_hi_nib, i_tok.nib};
    assign w_sum  = 8'(r_sum + w_byte);
    assign w_base = ADDR_W'({r_seg, 4'd0}) + ADDR_W'({r_addr_hi, w_byte});

    always_comb begin
        n_phase     = r_phase;
        n_nib_pend  = r_nib_pend;
        n_hi_nib    = r_hi_nib;
        n_count     = r_count;
        n_left      = r_left;
        n_addr_hi   = r_addr_hi;
        n_type      = r_type;
        n_sum       = r_sum;
        n_seg       = r_seg;
        n_base      = r_base;
        n_byte_addr = r_byte_addr;
        n_blk_open  = r_blk_open;
        n_blk_start = r_blk_start;
        n_blk_bytes = r_blk_bytes;
        n_blk_end   = r_blk_end;
        n_halted    = r_halted;
        w_load      = 1'b0;
        w_res       = '0;

        if (r_halted) begin
            // drop everything until reset
        end else if (r_phase == PH_TAIL) begin
            if (i_tok.cls == CLS_LF) begin
                n_phase = PH_COLON;
            end
        end else if (r_phase == PH_COLON) begin
            if (i_tok.cls != CLS_COLON) begin
                n_halted       = 1'b1;
                w_load         = 1'b1;
                w_res.kind     = KIND_ERR;
                w_res.error_code = ERR_COLON;
            end else begin
                n_phase    = PH_COUNT;
                n_nib_pend = 1'b0;
                n_sum      = 8'd0;
            end
        end else if (i_tok.cls != CLS_HEX) begin
            n_halted         = 1'b1;
            w_load           = 1'b1;
            w_res.kind       = KIND_ERR;
            w_res.error_code = ERR_DIGIT;
        end else if (!r_nib_pend) begin
            n_hi_nib   = i_tok.nib;
            n_nib_pend = 1'b1;
        end else begin
            n_nib_pend = 1'b0;
            n_sum      = w_sum;
            case (r_phase)
                PH_COUNT: begin
                    n_count = w_byte;
                    n_phase = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    n_addr_hi = w_byte;
                    n_phase   = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                    n_base  = w_base;
                    n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type = w_byte;
                    if (w_byte == REC_DATA) begin
                        if (r_count == 8'd0) begin
                            n_halted         = 1'b1;
                            w_load           = 1'b1;
                            w_res.kind       = KIND_ERR;
                            w_res.error_code = ERR_COUNT;
                        end else begin
                            n_left      = r_count;
                            n_phase     = PH_PAYLOAD;
                            n_byte_addr = r_base;
                            if (r_blk_open && r_base != r_blk_end) begin
                                w_load           = 1'b1;
                                w_res.kind       = KIND_BLOCK;
                                w_res.address    = r_blk_start;
                                w_res.block_size = r_blk_bytes;
                            end
                            if (!r_blk_open || r_base != r_blk_end) begin
                                n_blk_open  = 1'b1;
                                n_blk_start = r_base;
                                n_blk_bytes = '0;
                                n_blk_end   = r_base;
                            end
                        end
                    end else if (w_byte == REC_EOF) begin
                        if (r_count != 8'd0) begin
                            n_halted         = 1'b1;
                            w_load           = 1'b1;
                            w_res.kind       = KIND_ERR;
                            w_res.error_code = ERR_COUNT;
                        end else begin
                            n_phase = PH_CHECK;
                        end
                    end else if (w_byte == REC_SEG) begin
                        if (r_count != 8'd2) begin
                            n_halted         = 1'b1;
                            w_load           = 1'b1;
                            w_res.kind       = KIND_ERR;
                            w_res.error_code = ERR_COUNT;
                        end else begin
                            n_left  = 8'd2;
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_halted         = 1'b1;
                        w_load           = 1'b1;
                        w_res.kind       = KIND_ERR;
                        w_res.error_code = ERR_TYPE;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_type == REC_DATA) begin
                        w_load          = 1'b1;
                        w_res.kind      = KIND_DATA;
                        w_res.data_byte = w_byte;
                        w_res.address   = r_byte_addr;
                        n_byte_addr     = ADDR_W'(r_byte_addr + 1'b1);
                        n_blk_bytes     = ADDR_W'(r_blk_bytes + 1'b1);
                        n_blk_end       = ADDR_W'(r_blk_end + 1'b1);
                    end else begin
                        n_seg = {r_seg[7:0], w_byte};
                    end
                    n_left = 8'(r_left - 1'b1);
                    if (r_left == 8'd1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (w_sum != 8'd0) begin
                        n_halted         = 1'b1;
                        w_load           = 1'b1;
                        w_res.kind       = KIND_ERR;
                        w_res.error_code = ERR_CSUM;
                    end else if (r_type == REC_EOF) begin
                        n_halted         = 1'b1;
                        w_load           = 1'b1;
                        w_res.kind       = KIND_EOF;
                        w_res.address    = r_blk_open ? r_blk_start : '0;
                        w_res.block_size = r_blk_open ? r_blk_bytes : '0;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                default: begin
                    n_phase = PH_COLON;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COLON;
            r_nib_pend  <= 1'b0;
            r_halted    <= 1'b0;
            r_blk_open  <= 1'b0;
            r_seg       <= '0;
            r_blk_start <= '0;
            r_blk_bytes <= '0;
            r_blk_end   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_nib_pend  <= n_nib_pend;
                r_halted    <= n_halted;
                r_blk_open  <= n_blk_open;
                r_seg       <= n_seg;
                r_blk_start <= n_blk_start;
                r_blk_bytes <= n_blk_bytes;
                r_blk_end   <= n_blk_end;
            end
            if (o_pop && w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hi_nib    <= n_hi_nib;
            r_count     <= n_count;
            r_left      <= n_left;
            r_addr_hi   <= n_addr_hi;
            r_type      <= n_type;
            r_sum       <= n_sum;
            r_base      <= n_base;
            r_byte_addr <= n_byte_addr;
        end
        if (o_pop && w_load) begin
            r_out <= w_res;
        end
    end

    `IHEX_ASSERT(a_halt_silent, i_clk, i_rst_n, r_halted |-> !w_load)
    `IHEX_ASSERT(a_blk_end_sum, i_clk, i_rst_n, r_blk_end == ADDR_W'(r_blk_start + r_blk_bytes))
    `IHEX_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_fstat.empty |-> !o_pop)
    `IHEX_ASSERT(a_halt_sticks, i_clk, i_rst_n, r_halted |=> r_halted)

endmodule

>>> design/intel_hex_record_parser.sv
// Path: a taken character passes the front register, the token queue and the result register.
// Throughput: one character per cycle while o_stall is low; at most one result per character.
// The front register and a four-beat token queue let input and output stall independently.
// Reset (i_rst_n low, synchronous) empties the queue and output and restarts at the colon.
// A halt after end of file or an error lasts until the next reset.
module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_ch,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_data_byte,
    output logic [ADDR_W-1:0] o_address,
    output logic [ADDR_W-1:0] o_block_size,
    output logic [2:0]        o_error_code
);

    // queue status is shared by both sides
    t_fifo_stat w_fstat;
    t_tok       w_push_tok;
    t_tok       w_pop_tok;
    logic       w_push;
    logic       w_pop;
    t_res       w_res;

    // front: classify each character beat into a hex, colon, newline or other token
    ihex_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ch    (i_ch),
        .i_fstat (w_fstat),
        .o_push  (w_push),
        .o_tok   (w_push_tok)
    );

    // decouple: hold tokens while the result side is stalled
    ihex_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_push_tok),
        .i_pop   (w_pop),
        .o_tok   (w_pop_tok),
        .o_fstat (w_fstat)
    );

    // back: advance the record state and register the result beat
    ihex_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_pop_tok),
        .i_fstat (w_fstat),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_res)
    );

    assign o_kind       = w_res.kind;
    assign o_data_byte  = w_res.data_byte;
    assign o_address    = w_res.address;
    assign o_block_size = w_res.block_size;
    assign o_error_code = w_res.error_code;

endmodule

>>> dv/intel_hex_record_parser_tb.sv
// Self-checking testbench for the Intel HEX record parser: record streams against a local predictor.
`timescale 1ns / 100ps

module intel_hex_record_parser_tb;
    import ihex_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_CHARS = 280;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [2:0] NO_CODE = 3'd0;

    // where the predictor stands within a record line
    typedef enum logic [3:0] {
        P_COLON, P_COUNT, P_ADDR_HI, P_ADDR_LO, P_TYPE, P_PAYLOAD, P_CHECK, P_TAIL
    } t_line_phase;

    // how the run ends; the parser halts for good after any of these
    typedef enum int {
        END_EOF, END_EOF_BAD_SUM, END_DATA_BAD_SUM, END_BAD_DIGIT,
        END_NO_COLON, END_BAD_COUNT, END_BAD_TYPE
    } t_ending;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [7:0]        i_ch    = 8'h00;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_kind;
    logic [7:0]        o_data_byte;
    logic [ADDR_W-1:0] o_address;
    logic [ADDR_W-1:0] o_block_size;
    logic [2:0]        o_error_code;

    intel_hex_record_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_address    (o_address),
        .o_block_size (o_block_size),
        .o_error_code (o_error_code)
    );

    always #1 i_clk = ~i_clk;

    // parser state as predicted, at reset values
    t_line_phase       ph         = P_COLON;
    logic              nib_pend   = 1'b0;
    logic [3:0]        hi_nib     = 4'h0;
    logic [7:0]        rec_count  = 8'h00;
    logic [7:0]        bytes_left = 8'h00;
    logic [15:0]       rec_addr   = 16'h0000;
    logic [7:0]        rec_type   = 8'h00;
    logic [7:0]        line_sum   = 8'h00;
    logic [15:0]       seg_word   = 16'h0000;
    logic              blk_open   = 1'b0;
    logic [ADDR_W-1:0] blk_start  = '0;
    logic [ADDR_W-1:0] blk_bytes  = '0;
    logic              halted_q   = 1'b0;

    t_res expected_results[$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   chars_sent  = 0;
    int   hold_cycles = 0;
    logic steady      = 1'b0;      // when set, neither side idles
    logic [7:0] payload_buf [0:255];

    function automatic logic [ADDR_W-1:0] record_origin();
        return ADDR_W'({seg_word, 4'h0}) + ADDR_W'(rec_addr);
    endfunction

    task automatic push_result(input logic [1:0] k, input logic [7:0] d,
                               input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] s,
                               input logic [2:0] e);
        expected_results.push_back(t_res'{kind: k, data_byte: d, address: a,
                                          block_size: s, error_code: e});
    endtask

    task automatic raise_error(input logic [2:0] e);
        halted_q = 1'b1;
        push_result(KIND_ERR, 8'h00, '0, '0, e);
    endtask

    // Advance the predicted parser by one character and queue what it reports.
    task automatic parse_char(input logic [7:0] c);
        logic [4:0]        nib;
        logic [7:0]        b;
        logic [7:0]        idx;
        logic [ADDR_W-1:0] origin;
        if (halted_q) return;
        if (ph == P_TAIL) begin
            if (c == CH_LF) ph = P_COLON;
            return;
        end
        if (ph == P_COLON) begin
            if (c != CH_COLON) begin
                raise_error(ERR_COLON);
                return;
            end
            ph       = P_COUNT;
            nib_pend = 1'b0;
            line_sum = 8'h00;
            return;
        end
        // decode one hex digit, upper or lower case; bit 4 flags a good digit
        if (c >= 8'h30 && c <= 8'h39)
            nib = {1'b1, c[3:0]};
        else if (c >= 8'h41 && c <= 8'h46)
            nib = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            nib = {1'b1, 4'(c - 8'h57)};
        else
            nib = 5'd0;
        if (!nib[4]) begin
            raise_error(ERR_DIGIT);
            return;
        end
        if (!nib_pend) begin
            hi_nib   = nib[3:0];
            nib_pend = 1'b1;
            return;
        end
        nib_pend = 1'b0;
        b        = {hi_nib, nib[3:0]};
        line_sum = line_sum + b;
        case (ph)
            P_COUNT: begin
                rec_count = b;
                ph        = P_ADDR_HI;
            end
            P_ADDR_HI: begin
                rec_addr = {b, 8'h00};
                ph       = P_ADDR_LO;
            end
            P_ADDR_LO: begin
                rec_addr[7:0] = b;
                ph            = P_TYPE;
            end
            P_TYPE: begin
                rec_type = b;
                if (b == REC_DATA) begin
                    if (rec_count == 8'h00) begin
                        raise_error(ERR_COUNT);
                    end else begin
                        origin     = record_origin();
                        bytes_left = rec_count;
                        ph         = P_PAYLOAD;
                        // close the block when this record does not follow on
                        if (blk_open && origin != blk_start + blk_bytes) begin
                            push_result(KIND_BLOCK, 8'h00, blk_start, blk_bytes, NO_CODE);
                            blk_open = 1'b0;
                        end
                        if (!blk_open) begin
                            blk_open  = 1'b1;
                            blk_start = origin;
                            blk_bytes = '0;
                        end
                    end
                end else if (b == REC_EOF) begin
                    if (rec_count != 8'h00) raise_error(ERR_COUNT);
                    else ph = P_CHECK;
                end else if (b == REC_SEG) begin
                    if (rec_count != 8'h02) begin
                        raise_error(ERR_COUNT);
                    end else begin
                        bytes_left = 8'h02;
                        ph         = P_PAYLOAD;
                    end
                end else begin
                    raise_error(ERR_TYPE);
                end
            end
            P_PAYLOAD: begin
                if (rec_type == REC_DATA) begin
                    idx = rec_count - bytes_left;
                    push_result(KIND_DATA, b, record_origin() + ADDR_W'(idx), '0, NO_CODE);
                    blk_bytes = blk_bytes + 1'b1;
                end else begin
                    seg_word = {seg_word[7:0], b};
                end
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 8'h00) ph = P_CHECK;
            end
            default: begin
                if (line_sum != 8'h00) begin
                    raise_error(ERR_CSUM);
                end else if (rec_type == REC_EOF) begin
                    halted_q = 1'b1;
                    push_result(KIND_EOF, 8'h00, blk_open ? blk_start : '0,
                                blk_open ? blk_bytes : '0, NO_CODE);
                end else begin
                    ph = P_TAIL;
                end
            end
        endcase
    endtask

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // Send one character beat: idle for a drawn gap first, then hold it until the parser takes it.
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(c);
        chars_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + n;
    endfunction

    task automatic send_hex_byte(input logic [7:0] b);
        send_char(hex_char(b[7:4]));
        send_char(hex_char(b[3:0]));
    endtask

    // Send one record line from payload_buf; skew offsets the checksum, zero keeps it good.
    task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype, input int nbody,
                               input logic [7:0] skew);
        logic [7:0] sum;
        logic [7:0] tail_c;
        int         ntail;
        sum = count + addr[15:8] + addr[7:0] + rtype;
        send_char(CH_COLON);
        send_hex_byte(count);
        send_hex_byte(addr[15:8]);
        send_hex_byte(addr[7:0]);
        send_hex_byte(rtype);
        for (int k = 0; k < nbody; k++) begin
            send_hex_byte(payload_buf[k]);
            sum = sum + payload_buf[k];
        end
        send_hex_byte(skew - sum);
        // junk after the checksum, any byte but LF, then the line end
        ntail = $urandom_range(0, 3);
        repeat (ntail) begin
            do tail_c = 8'($urandom_range(0, 255)); while (tail_c == CH_LF);
            send_char(tail_c);
        end
        if ($urandom_range(0, 1)) send_char(CH_CR);
        send_char(CH_LF);
    endtask

    task automatic fill_payload(input int n);
        for (int k = 0; k < n; k++) payload_buf[k] = 8'($urandom_range(0, 255));
    endtask

    task automatic send_segment(input logic [15:0] w);
        payload_buf[0] = w[15:8];
        payload_buf[1] = w[7:0];
        send_record(8'h02, 16'($urandom_range(0, 16'hFFFF)), REC_SEG, 2, 8'h00);
    endtask

    task automatic send_data(input int count, input logic [15:0] addr);
        fill_payload(count);
        send_record(8'(count), addr, REC_DATA, count, 8'h00);
    endtask

    task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Compare one taken result beat with the oldest prediction.
    task automatic check_result();
        t_res want;
        if (expected_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual kind %0d addr %0h",
                     $time, o_kind, o_address);
            return;
        end
        want = expected_results.pop_front();
        if (want.kind !== o_kind) report_mismatch("kind", want.kind, o_kind);
        if (want.data_byte !== o_data_byte)
            report_mismatch("data_byte", want.data_byte, o_data_byte);
        if (want.address !== o_address) report_mismatch("address", want.address, o_address);
        if (want.block_size !== o_block_size)
            report_mismatch("block_size", want.block_size, o_block_size);
        if (want.error_code !== o_error_code)
            report_mismatch("error_code", want.error_code, o_error_code);
    endtask

    // Result side: check each taken beat, then stall for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                check_result();
                hold_cycles = draw_wait();
            end else if (hold_cycles > 0) begin
                hold_cycles--;
            end
            i_stall <= (hold_cycles > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Block edges, continuation across a segment change, top address and a long record.
    task automatic test_directed_records();
        send_segment(16'h0000);
        payload_buf[0] = 8'h00;
        send_record(8'h01, 16'h0000, REC_DATA, 1, 8'h00);
        payload_buf[0] = 8'hFF;
        payload_buf[1] = 8'hA5;
        send_record(8'h02, 16'h0001, REC_DATA, 2, 8'h00);
        send_data(3, 16'hFFFF);
        send_segment(16'h1000);
        send_data(4, 16'h0000);
        // 0x0FFF0 + 0x0014 lands on the end of the block above
        send_segment(16'h0FFF);
        send_data(4, 16'h0014);
        send_segment(16'hFFFF);
        send_data(64, 16'hFFFF);
    endtask

    // Well-formed lines with random content; most data records follow on from the open block.
    task automatic test_random_records();
        int                start;
        int                count;
        logic [15:0]       addr;
        logic [ADDR_W-1:0] offset;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS) begin
            if ($urandom_range(0, 5) == 0) steady = !steady;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       send_segment(16'h0000);
                    1:       send_segment(16'hFFFF);
                    default: send_segment(16'($urandom_range(0, 16'hFFFF)));
                endcase
            end else begin
                count  = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                      : $urandom_range(1, 16);
                offset = blk_start + blk_bytes - ADDR_W'({seg_word, 4'h0});
                if (blk_open && offset < ADDR_W'(17'h10000) && $urandom_range(0, 4) != 0)
                    addr = offset[15:0];
                else
                    addr = 16'($urandom_range(0, 16'hFFFF));
                send_data(count, addr);
            end
        end
        steady = 1'b0;
    endtask

    // One closing event per run, drawn at random: end of file or one of the errors.
    task automatic test_terminal_record();
        t_ending    pick;
        int         cnt;
        logic [7:0] c;
        pick = t_ending'($urandom_range(0, 6));
        cnt  = $urandom_range(1, 8);
        case (pick)
            END_EOF:
                send_record(8'h00, 16'($urandom_range(0, 16'hFFFF)), REC_EOF, 0, 8'h00);
            END_EOF_BAD_SUM:
                send_record(8'h00, 16'($urandom_range(0, 16'hFFFF)), REC_EOF, 0,
                            8'($urandom_range(1, 255)));
            END_DATA_BAD_SUM: begin
                fill_payload(cnt);
                send_record(8'(cnt), 16'($urandom_range(0, 16'hFFFF)), REC_DATA, cnt,
                            8'($urandom_range(1, 255)));
            end
            END_BAD_DIGIT: begin
                // break a digit somewhere in the count or address field
                send_char(CH_COLON);
                repeat ($urandom_range(0, 5)) send_char(hex_char(4'($urandom_range(0, 15))));
                do c = 8'($urandom_range(0, 255));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                       (c >= 8'h61 && c <= 8'h66));
                send_char(c);
            end
            END_NO_COLON: begin
                case ($urandom_range(0, 2))
                    0:       c = CH_CR;
                    1:       c = CH_LF;
                    default: do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
                endcase
                send_char(c);
            end
            END_BAD_COUNT: begin
                case ($urandom_range(0, 2))
                    0: send_record(8'h00, 16'($urandom_range(0, 16'hFFFF)), REC_DATA, 0,
                                   8'h00);
                    1: send_record(8'($urandom_range(1, 255)),
                                   16'($urandom_range(0, 16'hFFFF)), REC_EOF, 0, 8'h00);
                    default: begin
                        do c = 8'($urandom_range(0, 8)); while (c == 8'h02);
                        send_record(c, 16'($urandom_range(0, 16'hFFFF)), REC_SEG, 0, 8'h00);
                    end
                endcase
            end
            default:
                send_record(8'($urandom_range(0, 4)), 16'($urandom_range(0, 16'hFFFF)),
                            8'($urandom_range(3, 255)), 0, 8'h00);
        endcase
    endtask

    // Feed noise into the halted parser; nothing may come out.
    task automatic test_halted_input();
        repeat (24) send_char(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_records();
        test_random_records();
        test_terminal_record();
        test_halted_input();
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
